[hdl/msl_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helpers for the multi-servo slew limiter
// no dependencies; imported by every module of the block

package msl_pkg;

    // channel count and reset pulse
    localparam int SERVO_CHANNELS = 5;
    localparam int PULSE_CENTER   = 1500;

    // field and register widths
    localparam int SERVO_W   = 3;
    localparam int PULSE_W   = 15;
    localparam int REQ_W     = 16;
    localparam int TICKS_W   = 8;
    localparam int STEP_W    = 15;
    localparam int ADDR_W    = 5;
    localparam int APB_W     = 32;
    localparam int REG_IDX_W = 3;

    // stream payload widths, padded to whole bytes
    localparam int IN_BITS   = SERVO_W + 1 + REQ_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = SERVO_W + PULSE_W + 1 + 1 + STEP_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    // saturation value of the idle tick counter
    localparam logic [TICKS_W-1:0] IDLE_MAX = '1;

    // request kinds carried on tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // move flag code
    localparam logic MOVE_CODE = 1'b1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_BASE = 3'd3;

    // register reset values
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 15'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 15'd2500;
    localparam logic [TICKS_W-1:0] TIMEOUT_RST   = 8'd20;
    localparam logic [STEP_W-1:0]  STEP_RST      = 15'd10;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef logic [STEP_W-1:0] step_arr_t [SERVO_CHANNELS];

    // configuration seen by the datapath
    typedef struct packed {
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_max;
        logic [TICKS_W-1:0] timeout_ticks;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic               load_req;
        logic               start_tick;
        logic               a_en;
        logic [SERVO_W-1:0] a_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic a_valid;
        logic stall;
    } status_t;

    // low bound is tested first, so an inverted range lands on a bound
    function automatic logic [PULSE_W-1:0] clamp_safe(
        input logic [REQ_W-1:0]   v,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        logic [PULSE_W-1:0] r;
        if (v < REQ_W'(lo)) begin
            r = lo;
        end else if (v > REQ_W'(hi)) begin
            r = hi;
        end else begin
            r = v[PULSE_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/multi_servo_slew_limiter_unit.sv]
`timescale 1ns / 1ps
// top level of the multi-servo slew limiter: register file, controller, datapath
// depends on msl_pkg, msl_cfg, msl_ctrl and msl_dpath

// Five servo channels with slew limiting and a command timeout. A load
// transfer (tuser high) latches one servo's move flag and pulse. A tick
// transfer (tuser low) sends one result per servo, servo zero first, tlast
// on the last; results come one per cycle while the output is not stalled,
// behind a two-stage target/step pipeline and an output register. After a
// tick is accepted the controller walks the five channels through the
// target stage, and the next transfer is accepted once the last channel
// has left it. Output backpressure stalls the walk. Registers are written
// over APB at byte address 4*index.

module multi_servo_slew_limiter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msl_pkg::ADDR_W-1:0]  paddr,
    input  logic [msl_pkg::APB_W-1:0]   pwdata,
    output logic [msl_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    // requests and ticks
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // servo_index[2:0], move_request[3], cmd_pulse[19:4]
    input  logic [msl_pkg::IN_W-1:0]    s_tdata,
    // req_type[0]
    input  logic                        s_tuser,
    // per-servo results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_servo[2:0], pulse_width[17:3], pulse_changed[18], active[19], step_us[34:20]
    output logic [msl_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast
);
    import msl_pkg::*;

    cfg_t               cfg;
    step_arr_t          step;
    cmd_t               cmd;
    status_t            st;
    logic [SERVO_W-1:0] req_servo;
    logic               req_move;
    logic [REQ_W-1:0]   req_pulse;

    // unpack the request transfer
    assign req_servo = s_tdata[SERVO_W-1:0];
    assign req_move  = s_tdata[SERVO_W];
    assign req_pulse = s_tdata[SERVO_W+REQ_W:SERVO_W+1];

    msl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .step    (step)
    );

    msl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    msl_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (step),
        .cmd       (cmd),
        .st        (st),
        .req_servo (req_servo),
        .req_move  (req_move),
        .req_pulse (req_pulse),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[hdl/msl_cfg.sv]
`timescale 1ns / 1ps
// apb register file: safe pulse range, timeout and per-servo step sizes
// depends on msl_pkg

module msl_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msl_pkg::ADDR_W-1:0]  paddr,
    input  logic [msl_pkg::APB_W-1:0]   pwdata,
    output logic [msl_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    output msl_pkg::cfg_t               cfg,
    output msl_pkg::step_arr_t          step
);
    import msl_pkg::*;

    logic [PULSE_W-1:0]   pulse_min_reg;
    logic [PULSE_W-1:0]   pulse_max_reg;
    logic [TICKS_W-1:0]   timeout_reg;
    logic [STEP_W-1:0]    step_reg [SERVO_CHANNELS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic [REG_IDX_W-1:0] step_idx;
    logic                 step_hit;
    logic                 wr;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[ADDR_W-1:2];
    assign wr       = psel && penable && pwrite;
    assign step_idx = reg_idx - REG_STEP_BASE;
    assign step_hit = (reg_idx >= REG_STEP_BASE) &&
                      (step_idx < REG_IDX_W'(SERVO_CHANNELS));

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_min_reg <= PULSE_MIN_RST;
            pulse_max_reg <= PULSE_MAX_RST;
            timeout_reg   <= TIMEOUT_RST;
            for (int i = 0; i < SERVO_CHANNELS; i++) begin
                step_reg[i] <= STEP_RST;
            end
        end else if (wr) begin
            priority if (reg_idx == REG_PULSE_MIN) begin
                pulse_min_reg <= pwdata[PULSE_W-1:0];
            end else if (reg_idx == REG_PULSE_MAX) begin
                pulse_max_reg <= pwdata[PULSE_W-1:0];
            end else if (reg_idx == REG_TIMEOUT) begin
                timeout_reg <= pwdata[TICKS_W-1:0];
            end else if (step_hit) begin
                step_reg[step_idx] <= pwdata[STEP_W-1:0];
            end else begin
                pulse_min_reg <= pulse_min_reg;
            end
        end
    end

    // read mux
    always_comb begin
        priority if (reg_idx == REG_PULSE_MIN) begin
            prdata = APB_W'(pulse_min_reg);
        end else if (reg_idx == REG_PULSE_MAX) begin
            prdata = APB_W'(pulse_max_reg);
        end else if (reg_idx == REG_TIMEOUT) begin
            prdata = APB_W'(timeout_reg);
        end else if (step_hit) begin
            prdata = APB_W'(step_reg[step_idx]);
        end else begin
            prdata = '0;
        end
    end

    assign cfg.pulse_min     = pulse_min_reg;
    assign cfg.pulse_max     = pulse_max_reg;
    assign cfg.timeout_ticks = timeout_reg;
    assign step              = step_reg;

endmodule

[hdl/msl_ctrl.sv]
`timescale 1ns / 1ps
// controller: accepts transfers and walks the servo channels of a tick
// depends on msl_pkg

module msl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  msl_pkg::status_t    st,
    output msl_pkg::cmd_t       cmd
);
    import msl_pkg::*;

    state_t             state_reg, state_next;
    logic [SERVO_W-1:0] cnt_reg, cnt_next;
    logic               accept;

    // state and channel counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        s_tready       = 1'b0;
        cmd.load_req   = 1'b0;
        cmd.start_tick = 1'b0;
        cmd.a_en       = 1'b0;
        cmd.a_idx      = cnt_reg;
        accept         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // wait for the last channel to leave the first stage
                s_tready = !st.a_valid;
                accept   = s_tvalid && s_tready;
                if (accept) begin
                    if (s_tuser == REQ_TICK) begin
                        cmd.start_tick = 1'b1;
                        cnt_next       = '0;
                        state_next     = ST_RUN;
                    end else begin
                        cmd.load_req = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (!st.stall) begin
                    cmd.a_en = 1'b1;
                    if (cnt_reg == SERVO_W'(SERVO_CHANNELS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/msl_dpath.sv]
`timescale 1ns / 1ps
// datapath: per-servo state, target stage, step stage and output register
// depends on msl_pkg

module msl_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  msl_pkg::cfg_t               cfg,
    input  msl_pkg::step_arr_t          step,
    input  msl_pkg::cmd_t               cmd,
    output msl_pkg::status_t            st,
    input  logic [msl_pkg::SERVO_W-1:0] req_servo,
    input  logic                        req_move,
    input  logic [msl_pkg::REQ_W-1:0]   req_pulse,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [msl_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast
);
    import msl_pkg::*;

    // per-servo state
    logic [PULSE_W-1:0] cur_reg     [SERVO_CHANNELS];
    logic [PULSE_W-1:0] tgt_reg     [SERVO_CHANNELS];
    logic [PULSE_W-1:0] written_reg [SERVO_CHANNELS];
    logic               moving_reg  [SERVO_CHANNELS];
    logic               lmove_reg   [SERVO_CHANNELS];
    logic [REQ_W-1:0]   lpulse_reg  [SERVO_CHANNELS];
    logic [TICKS_W-1:0] idle_reg;
    logic               timed_out_reg;

    // target stage registers
    logic               a_valid_reg;
    logic [SERVO_W-1:0] a_servo_reg;
    logic [PULSE_W-1:0] a_cur_reg;
    logic [PULSE_W-1:0] a_tgt_reg;
    logic               a_mv_reg;
    logic [STEP_W-1:0]  a_step_reg;

    // output register
    logic               out_valid_reg;
    logic [SERVO_W-1:0] out_servo_reg;
    logic [PULSE_W-1:0] out_pulse_reg;
    logic               out_changed_reg;
    logic               out_active_reg;
    logic [STEP_W-1:0]  out_step_reg;
    logic               out_last_reg;

    logic               en;
    logic               b_en;
    logic               req_ok;

    // target stage signals
    logic [PULSE_W-1:0] a_cur;
    logic [PULSE_W-1:0] lat_clamped;
    logic [PULSE_W-1:0] tgt_new;
    logic [PULSE_W-1:0] tgt_use;
    logic               mv_new;

    // step stage signals
    logic [PULSE_W-1:0] dn_diff;
    logic [PULSE_W-1:0] up_diff;
    logic [PULSE_W-1:0] nc;
    logic [PULSE_W-1:0] ncc;
    logic               at_tgt;
    logic               b_active;
    logic               b_changed;
    logic [STEP_W-1:0]  b_step;

    assign en         = !(out_valid_reg && !m_tready);
    assign b_en       = en && a_valid_reg;
    assign st.a_valid = a_valid_reg;
    assign st.stall   = !en;
    assign req_ok     = req_servo < SERVO_W'(SERVO_CHANNELS);

    // request latch and command timeout
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg      <= '0;
            timed_out_reg <= 1'b0;
            for (int i = 0; i < SERVO_CHANNELS; i++) begin
                lmove_reg[i]  <= 1'b0;
                lpulse_reg[i] <= '0;
            end
        end else begin
            if (cmd.load_req && req_ok) begin
                lmove_reg[req_servo]  <= (req_move == MOVE_CODE);
                lpulse_reg[req_servo] <= req_pulse;
                idle_reg              <= '0;
            end
            if (cmd.start_tick) begin
                timed_out_reg <= (idle_reg >= cfg.timeout_ticks);
                if (idle_reg != IDLE_MAX) begin
                    idle_reg <= idle_reg + 1'b1;
                end
            end
        end
    end

    // target selection for the channel in the first stage
    always_comb begin
        a_cur       = cur_reg[cmd.a_idx];
        lat_clamped = clamp_safe(lpulse_reg[cmd.a_idx], cfg.pulse_min, cfg.pulse_max);
        if (timed_out_reg) begin
            // freeze at the current pulse
            tgt_new = a_cur;
            mv_new  = 1'b0;
        end else if (lmove_reg[cmd.a_idx]) begin
            tgt_new = lat_clamped;
            mv_new  = (lat_clamped != a_cur);
        end else begin
            tgt_new = tgt_reg[cmd.a_idx];
            mv_new  = moving_reg[cmd.a_idx];
        end
        // stepping always heads for the clamped value of the stored target
        tgt_use = clamp_safe(REQ_W'(tgt_new), cfg.pulse_min, cfg.pulse_max);
    end

    // slew step for the channel in the second stage
    always_comb begin
        dn_diff = a_cur_reg - a_tgt_reg;
        up_diff = a_tgt_reg - a_cur_reg;
        if (a_tgt_reg < a_cur_reg) begin
            nc = (dn_diff <= a_step_reg) ? a_tgt_reg : (a_cur_reg - a_step_reg);
        end else if (a_tgt_reg > a_cur_reg) begin
            nc = (up_diff <= a_step_reg) ? a_tgt_reg : (a_cur_reg + a_step_reg);
        end else begin
            nc = a_cur_reg;
        end
        ncc       = clamp_safe(REQ_W'(nc), cfg.pulse_min, cfg.pulse_max);
        at_tgt    = (ncc == a_tgt_reg);
        b_active  = at_tgt ? 1'b0 : a_mv_reg;
        b_step    = at_tgt ? '0 : a_step_reg;
        b_changed = (ncc != written_reg[a_servo_reg]);
    end

    // per-servo state updates from both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SERVO_CHANNELS; i++) begin
                cur_reg[i]     <= PULSE_W'(PULSE_CENTER);
                tgt_reg[i]     <= PULSE_W'(PULSE_CENTER);
                written_reg[i] <= PULSE_W'(PULSE_CENTER);
                moving_reg[i]  <= 1'b0;
            end
        end else begin
            if (cmd.a_en) begin
                tgt_reg[cmd.a_idx]    <= tgt_new;
                moving_reg[cmd.a_idx] <= mv_new;
            end
            if (b_en) begin
                cur_reg[a_servo_reg]    <= ncc;
                moving_reg[a_servo_reg] <= b_active;
                if (b_changed) begin
                    written_reg[a_servo_reg] <= ncc;
                end
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= cmd.a_en;
            out_valid_reg <= a_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (cmd.a_en) begin
            a_servo_reg <= cmd.a_idx;
            a_cur_reg   <= a_cur;
            a_tgt_reg   <= tgt_use;
            a_mv_reg    <= mv_new;
            a_step_reg  <= step[cmd.a_idx];
        end
        if (b_en) begin
            out_servo_reg   <= a_servo_reg;
            out_pulse_reg   <= ncc;
            out_changed_reg <= b_changed;
            out_active_reg  <= b_active;
            out_step_reg    <= b_step;
            out_last_reg    <= (a_servo_reg == SERVO_W'(SERVO_CHANNELS - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_step_reg, out_active_reg, out_changed_reg,
                              out_pulse_reg, out_servo_reg});

    // the two stages never hold the same channel
    a_stage_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.a_en && a_valid_reg) |-> (cmd.a_idx != a_servo_reg))
        else $error("both stages on one servo");

    // a new tick never starts while the first stage still holds a channel
    a_tick_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_tick |-> !a_valid_reg)
        else $error("tick started with busy stage");

    // tlast is carried only by the final channel of a tick
    a_last_servo: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (out_servo_reg == SERVO_W'(SERVO_CHANNELS - 1)))
        else $error("tlast on wrong servo");

    // a stalled step stage keeps its channel
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !en) |=> $stable(a_servo_reg) && a_valid_reg)
        else $error("step stage lost its channel while stalled");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for multi_servo_slew_limiter_unit: apb register writes,
// stream stimulus with random idling on both sides, and a cycle-free servo model
// depends on msl_pkg and multi_servo_slew_limiter_unit

module tb_top;

    import msl_pkg::*;

    localparam int IDLE_PCT      = 25;
    localparam int SETTLE_CYCLES = 12;
    localparam int RAND_PHASES   = 4;
    localparam int PHASE_ITEMS   = 8;
    localparam int CALM_PHASE    = 3;
    localparam int HOLD_TICKS    = 258;
    localparam int PULSE_LIMIT   = 20000;
    localparam int REG_COUNT     = REG_STEP_BASE + SERVO_CHANNELS;
    localparam logic [REG_IDX_W-1:0] REG_STEP_SHOULDER = REG_STEP_BASE + 3'd1;

    // one per-servo result of a tick
    typedef struct {
        logic [SERVO_W-1:0] servo;
        logic [PULSE_W-1:0] pulse;
        logic               changed;
        logic               active;
        logic [STEP_W-1:0]  step;
        logic               last;
    } servo_res_t;

    // one row of the directed table: either a register write or a stream item
    typedef struct {
        bit                   is_write;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [PULSE_W-1:0]   reg_val;
        logic                 kind;
        logic [SERVO_W-1:0]   idx;
        logic                 mv;
        logic [REQ_W-1:0]     pulse;
        bit                   at_rest;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;
    logic               s_tvalid;
    logic               s_tready;
    // servo_index[2:0], move_request[3], cmd_pulse[19:4]
    logic [IN_W-1:0]    s_tdata;
    // req_type[0]
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // out_servo[2:0], pulse_width[17:3], pulse_changed[18], active[19], step_us[34:20]
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tlast;

    bit steady = 1'b0;
    int mismatches = 0;

    // model state and register copies
    logic [PULSE_W-1:0] floor_cfg;
    logic [PULSE_W-1:0] ceil_cfg;
    logic [TICKS_W-1:0] timeout_cfg;
    logic [STEP_W-1:0]  step_cfg   [SERVO_CHANNELS];
    logic [REQ_W-1:0]   cur_us     [SERVO_CHANNELS];
    logic [REQ_W-1:0]   target_us  [SERVO_CHANNELS];
    logic [REQ_W-1:0]   sent_us    [SERVO_CHANNELS];
    logic               in_motion  [SERVO_CHANNELS];
    logic               hold_move  [SERVO_CHANNELS];
    logic [REQ_W-1:0]   hold_pulse [SERVO_CHANNELS];
    logic [TICKS_W-1:0] idle_count;

    servo_res_t tick_res [SERVO_CHANNELS];
    servo_res_t servo_reports_due [$];
    dir_row_t   dir_rows [$];

    multi_servo_slew_limiter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop for a hung run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------- servo model ----------------

    function automatic void reset_model();
        floor_cfg   = PULSE_MIN_RST;
        ceil_cfg    = PULSE_MAX_RST;
        timeout_cfg = TIMEOUT_RST;
        idle_count  = '0;
        for (int s = 0; s < SERVO_CHANNELS; s++) begin
            step_cfg[s]   = STEP_RST;
            cur_us[s]     = REQ_W'(PULSE_CENTER);
            target_us[s]  = REQ_W'(PULSE_CENTER);
            sent_us[s]    = REQ_W'(PULSE_CENTER);
            in_motion[s]  = 1'b0;
            hold_move[s]  = 1'b0;
            hold_pulse[s] = '0;
        end
    endfunction

    function automatic void store_register(logic [REG_IDX_W-1:0] r, logic [PULSE_W-1:0] v);
        if (r == REG_PULSE_MIN) begin
            floor_cfg = v;
        end else if (r == REG_PULSE_MAX) begin
            ceil_cfg = v;
        end else if (r == REG_TIMEOUT) begin
            timeout_cfg = v[TICKS_W-1:0];
        end else begin
            step_cfg[r - REG_STEP_BASE] = v;
        end
    endfunction

    // floor is tested first, so an inverted safe range lands on a bound
    function automatic logic [REQ_W-1:0] safe_pulse(logic [REQ_W-1:0] v);
        logic [REQ_W-1:0] lo;
        logic [REQ_W-1:0] hi;
        lo = {1'b0, floor_cfg};
        hi = {1'b0, ceil_cfg};
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void latch_request(logic [SERVO_W-1:0] idx, logic mv,
                                          logic [REQ_W-1:0] p);
        // out-of-range servo: no latch, timeout keeps running
        if (idx < SERVO_CHANNELS) begin
            hold_move[idx]  = (mv == MOVE_CODE);
            hold_pulse[idx] = p;
            idle_count      = '0;
        end
    endfunction

    // one control tick over all servos, results into tick_res
    function automatic void slew_tick();
        logic              timed_out;
        logic [REQ_W-1:0]  tgt;
        logic [REQ_W-1:0]  cur;
        logic [STEP_W-1:0] step;
        timed_out = (idle_count >= timeout_cfg);
        if (idle_count != IDLE_MAX) begin
            idle_count = idle_count + 1'b1;
        end
        for (int s = 0; s < SERVO_CHANNELS; s++) begin
            if (timed_out) begin
                target_us[s] = cur_us[s];
                in_motion[s] = 1'b0;
            end else if (hold_move[s]) begin
                target_us[s] = safe_pulse(hold_pulse[s]);
                in_motion[s] = (target_us[s] != cur_us[s]);
            end
            // stored target may sit outside the range, stepping uses it clamped
            tgt  = safe_pulse(target_us[s]);
            step = step_cfg[s];
            cur  = cur_us[s];
            if (tgt < cur) begin
                cur = (cur - tgt <= step) ? tgt : cur - step;
            end else if (tgt > cur) begin
                cur = (tgt - cur <= step) ? tgt : cur + step;
            end
            cur       = safe_pulse(cur);
            cur_us[s] = cur;
            if (cur == tgt) begin
                step         = '0;
                in_motion[s] = 1'b0;
            end
            tick_res[s].servo   = SERVO_W'(s);
            tick_res[s].pulse   = cur[PULSE_W-1:0];
            tick_res[s].changed = (cur != sent_us[s]);
            tick_res[s].active  = in_motion[s];
            tick_res[s].step    = step;
            tick_res[s].last    = (s == SERVO_CHANNELS - 1);
            if (tick_res[s].changed) begin
                sent_us[s] = cur;
            end
        end
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want, input int servo);
        if (got != want) begin
            report_mismatch($sformatf("servo %0d %s: got %0d, expected %0d",
                                      servo, name, got, want));
        end
    endtask

    // compare every result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        servo_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (servo_reports_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result transfer, data %h", m_tdata));
            end else begin
                want = servo_reports_due.pop_front();
                check_field("servo", m_tdata[SERVO_W-1:0], want.servo, want.servo);
                check_field("pulse", m_tdata[SERVO_W +: PULSE_W], want.pulse, want.servo);
                check_field("changed", m_tdata[SERVO_W + PULSE_W], want.changed, want.servo);
                check_field("active", m_tdata[SERVO_W + PULSE_W + 1], want.active, want.servo);
                check_field("step", m_tdata[SERVO_W + PULSE_W + 2 +: STEP_W], want.step,
                            want.servo);
                check_field("last", m_tlast, want.last, want.servo);
            end
        end
    end

    // ---------------- drivers ----------------

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] r, input logic [PULSE_W-1:0] v);
        @(negedge aclk);
        // no stream transfer while the register changes
        s_tvalid = 1'b0;
        psel     = 1'b1;
        penable  = 1'b0;
        pwrite   = 1'b1;
        paddr    = ADDR_W'({r, 2'b00});
        pwdata   = APB_W'(v);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        store_register(r, v);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop sending and let every expected result come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (servo_reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one input transfer; at_rest means every servo is expected idle at center
    task automatic send_item(input logic kind, input logic [SERVO_W-1:0] idx, input logic mv,
                             input logic [REQ_W-1:0] p, input bit at_rest);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = IN_W'({p, mv, idx});
        do @(posedge aclk); while (!s_tready);
        if (kind == REQ_LOAD) begin
            latch_request(idx, mv, p);
        end else begin
            slew_tick();
            for (int s = 0; s < SERVO_CHANNELS; s++) begin
                if (at_rest) begin
                    tick_res[s].pulse   = PULSE_W'(PULSE_CENTER);
                    tick_res[s].changed = 1'b0;
                    tick_res[s].active  = 1'b0;
                    tick_res[s].step    = '0;
                end
                servo_reports_due.push_back(tick_res[s]);
            end
        end
    endtask

    // ---------------- random value pickers ----------------

    function automatic logic [PULSE_W-1:0] pick_reg_value(int r);
        int roll;
        roll = $urandom_range(0, 99);
        case (r)
            REG_PULSE_MIN: return PULSE_W'((roll < 10) ? 0 : (roll < 15) ? PULSE_LIMIT
                                  : $urandom_range(0, 1500));
            REG_PULSE_MAX: return PULSE_W'((roll < 10) ? PULSE_LIMIT : (roll < 15) ? 0
                                  : $urandom_range(1500, 4000));
            REG_TIMEOUT:   return PULSE_W'((roll < 10) ? 255 : (roll < 15) ? 1
                                  : $urandom_range(1, 12));
            default:       return PULSE_W'((roll < 10) ? 0 : (roll < 20) ? PULSE_LIMIT
                                  : $urandom_range(1, 400));
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_pulse();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return REQ_W'($urandom_range(0, 65535));
        end else if (roll < 25) begin
            return REQ_W'($urandom_range(0, PULSE_LIMIT));
        end
        return REQ_W'($urandom_range(300, 2700));
    endfunction

    task automatic shuffle_registers(input bit every);
        for (int r = 0; r < REG_COUNT; r++) begin
            if (every || $urandom_range(0, 1)) begin
                apb_write(REG_IDX_W'(r), pick_reg_value(r));
            end
        end
    endtask

    function automatic dir_row_t reg_row(logic [REG_IDX_W-1:0] r, logic [PULSE_W-1:0] v);
        dir_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = r;
        row.reg_val  = v;
        return row;
    endfunction

    function automatic dir_row_t item_row(logic kind, logic [SERVO_W-1:0] idx, logic mv,
                                          logic [REQ_W-1:0] p, bit at_rest);
        dir_row_t row;
        row         = '{default: '0};
        row.kind    = kind;
        row.idx     = idx;
        row.mv      = mv;
        row.pulse   = p;
        row.at_rest = at_rest;
        return row;
    endfunction

    // ---------------- stimulus ----------------

    initial begin
        int   counted;
        int   roll;
        logic no_move;
        no_move  = ~MOVE_CODE;
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_TICK;
        reset_model();

        // directed table
        // tick straight after reset: everything idle at center
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b1));
        // zero timeout freezes even with a latched move
        dir_rows.push_back(item_row(REQ_LOAD, 3'd0, MOVE_CODE, 16'hFFFF, 1'b0));
        dir_rows.push_back(reg_row(REG_TIMEOUT, 15'd0));
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b1));
        dir_rows.push_back(reg_row(REG_TIMEOUT, 15'd255));
        // extremes of the requested pulse, a non-move load, out-of-range servos
        dir_rows.push_back(item_row(REQ_LOAD, 3'd0, MOVE_CODE, 16'hFFFF, 1'b0));
        dir_rows.push_back(item_row(REQ_LOAD, 3'd1, MOVE_CODE, 16'd0, 1'b0));
        dir_rows.push_back(item_row(REQ_LOAD, 3'd2, no_move, 16'h8000, 1'b0));
        dir_rows.push_back(item_row(REQ_LOAD, SERVO_W'(SERVO_CHANNELS), MOVE_CODE,
                                    16'd1000, 1'b0));
        dir_rows.push_back(item_row(REQ_LOAD, 3'd7, MOVE_CODE, 16'hFFFF, 1'b0));
        // target within one step
        dir_rows.push_back(item_row(REQ_LOAD, 3'd3, MOVE_CODE, 16'd1503, 1'b0));
        dir_rows.push_back(reg_row(REG_STEP_BASE, 15'd20000));
        dir_rows.push_back(reg_row(REG_STEP_SHOULDER, 15'd0));
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b0));
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b0));
        // inverted safe range
        dir_rows.push_back(reg_row(REG_PULSE_MIN, 15'd3000));
        dir_rows.push_back(reg_row(REG_PULSE_MAX, 15'd1000));
        dir_rows.push_back(item_row(REQ_LOAD, 3'd4, MOVE_CODE, 16'd2000, 1'b0));
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b0));
        // widest safe range; tick with all other fields set
        dir_rows.push_back(reg_row(REG_PULSE_MIN, 15'd0));
        dir_rows.push_back(reg_row(REG_PULSE_MAX, 15'd20000));
        dir_rows.push_back(item_row(REQ_LOAD, 3'd4, MOVE_CODE, 16'd20000, 1'b0));
        dir_rows.push_back(item_row(REQ_TICK, 3'd7, MOVE_CODE, 16'hFFFF, 1'b0));
        // shortest timeout: second tick without a request freezes
        dir_rows.push_back(reg_row(REG_TIMEOUT, 15'd1));
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b0));
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b0));
        dir_rows.push_back(item_row(REQ_TICK, 3'd0, no_move, 16'd0, 1'b0));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_write) begin
                drain_results();
                apb_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_item(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].mv,
                          dir_rows[i].pulse, dir_rows[i].at_rest);
            end
        end

        // random phases: new settings, then loads and ticks with some junk requests
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            steady = (ph == CALM_PHASE);
            shuffle_registers(ph == 0);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    send_item(REQ_TICK, SERVO_W'($urandom_range(0, 7)),
                              logic'($urandom_range(0, 1)),
                              REQ_W'($urandom_range(0, 65535)), 1'b0);
                    counted++;
                end else if (roll < 90) begin
                    send_item(REQ_LOAD, SERVO_W'($urandom_range(0, SERVO_CHANNELS - 1)),
                              ($urandom_range(0, 99) < 85) ? MOVE_CODE : no_move,
                              pick_pulse(), 1'b0);
                    counted++;
                end else begin
                    send_item(REQ_LOAD, SERVO_W'($urandom_range(SERVO_CHANNELS, 7)),
                              logic'($urandom_range(0, 1)),
                              REQ_W'($urandom_range(0, 65535)), 1'b0);
                end
            end
        end

        // long stretch of ticks with no request: idle counter must saturate
        drain_results();
        steady = 1'b0;
        apb_write(REG_PULSE_MIN, 15'd0);
        apb_write(REG_PULSE_MAX, 15'd20000);
        apb_write(REG_TIMEOUT, 15'd255);
        for (int s = 0; s < SERVO_CHANNELS; s++) begin
            apb_write(REG_STEP_BASE + REG_IDX_W'(s), 15'd1);
            send_item(REQ_LOAD, SERVO_W'(s), MOVE_CODE,
                      REQ_W'($urandom_range(0, PULSE_LIMIT)), 1'b0);
        end
        for (int t = 0; t < HOLD_TICKS; t++) begin
            // second half runs with no idling on either side
            steady = (t >= HOLD_TICKS / 2);
            send_item(REQ_TICK, SERVO_W'($urandom_range(0, 7)), logic'($urandom_range(0, 1)),
                      REQ_W'($urandom_range(0, 65535)), 1'b0);
        end

        drain_results();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/msl_pkg.sv
hdl/msl_cfg.sv
hdl/msl_ctrl.sv
hdl/msl_dpath.sv
hdl/multi_servo_slew_limiter_unit.sv
tb/sv/tb_top.sv
